>>> rtl/gbn_pkg.sv
// Go-Back-N sender window: shared types, codes and constants.
// No dependencies; imported by every other file of the block but gbn_stream_if.
package gbn_pkg;

  localparam int unsigned SEQ_BITS = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // largest usable sequence number (all-ones is kept out of use)
  localparam logic [SEQ_BITS-1:0] SEQ_LAST = {{(SEQ_BITS-1){1'b1}}, 1'b0};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd2;

  // reset values of the configuration registers
  localparam logic [4:0]  WINDOW_RST  = 5'd4;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [15:0] TOTAL_RST   = 16'd1;

  // input opcodes
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  typedef enum logic [2:0] {
    K_NONE     = 3'd0,
    K_FULL     = 3'd1,
    K_AWAIT    = 3'd2,
    K_SEND_NEW = 3'd3,
    K_RESEND   = 3'd4,
    K_FINISHED = 3'd5,
    K_ACK_OK   = 3'd6,
    K_ACK_IGN  = 3'd7
  } kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] ack_number;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seq_number;
    logic        last_of_run;
    logic [15:0] window_base;
    logic [15:0] next_sequence;
    logic        timer_running;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic take;  // input transfer this cycle
    logic step;  // emit next resend of a run
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;     // output register can load this cycle
    logic resend_multi; // current input starts a resend run of two or more
    logic resend_last;  // next resend step is the final one
  } stat_t;

endpackage

>>> rtl/gbn_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Payload types come from gbn_pkg.
interface gbn_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/gbn_ctrl.sv
// Go-Back-N sender controller: idle / resend-run state machine.
// Depends on gbn_pkg (cmd_t, stat_t).
module gbn_ctrl import gbn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESEND = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign cmd_o.take = in_valid_i && in_ready_o;
  assign cmd_o.step = (state_q == S_RESEND) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.take && stat_i.resend_multi) state_d = S_RESEND;
      end
      S_RESEND: begin
        if (cmd_o.step && stat_i.resend_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_take_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !cmd_o.take)
    else $error("input taken during resend run");

endmodule

>>> rtl/gbn_dp.sv
// Go-Back-N sender datapath: config registers, window/timer state, result register.
// Depends on gbn_pkg; driven by gbn_ctrl commands.
module gbn_dp import gbn_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  req_t                 in_data_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_data_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned EXT_W = SEQ_BITS + 1;

  // configuration
  logic [4:0]  window_q;
  logic [15:0] timeout_q, total_q;

  // window and timer state
  logic [SEQ_BITS-1:0] base_q, base_d, next_q, next_d;
  logic                on_q, on_d;
  logic [15:0]         tcnt_q, tcnt_d;

  // resend run
  logic [CNT_W-1:0] idx_q, idx_d, rcnt_q, rcnt_d;

  // result register
  logic out_valid_q;
  rsp_t rsp_q, rsp_d;
  logic load;

  // decode of the current item
  logic [EXT_W-1:0]    win_s, ack1, elapsed;
  logic [SEQ_BITS-1:0] total_eff, outstanding;
  logic [CNT_W-1:0]    rcount;
  logic                full, done, ack_ign, expire;
  kind_e               kind_d;
  logic [SEQ_BITS-1:0] seq_d;
  logic                last_d;

  always_comb begin
    win_s = (EXT_W'(window_q) > EXT_W'(WINDOW_MAX)) ? EXT_W'(WINDOW_MAX) : EXT_W'(window_q);
    full  = EXT_W'(next_q) >= (EXT_W'(base_q) + win_s);
    total_eff = (total_q > SEQ_LAST) ? SEQ_LAST : total_q;
    done  = next_q > total_eff;
    ack1  = EXT_W'(in_data_i.ack_number) + EXT_W'(1);
    ack_ign = (ack1 < EXT_W'(base_q)) || (ack1 > EXT_W'(next_q));
    elapsed = EXT_W'(tcnt_q) + EXT_W'(1);
    expire  = on_q && (elapsed > EXT_W'(timeout_q));
    outstanding = next_q - base_q;
    rcount = (EXT_W'(outstanding) > EXT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX)
                                                        : outstanding[CNT_W-1:0];
  end

  assign stat_o.out_free     = !out_valid_q || out_ready_i;
  assign stat_o.resend_multi = (in_data_i.op == OP_TICK) && expire && (rcount > CNT_W'(1));
  assign stat_o.resend_last  = ((idx_q + CNT_W'(1)) == rcnt_q);

  always_comb begin
    base_d = base_q;
    next_d = next_q;
    on_d   = on_q;
    tcnt_d = tcnt_q;
    idx_d  = idx_q;
    rcnt_d = rcnt_q;
    kind_d = K_NONE;
    seq_d  = '0;
    last_d = 1'b1;
    if (cmd_i.take) begin
      case (in_data_i.op)
        OP_SEND: begin
          seq_d = next_q;
          if (full) begin
            kind_d = K_FULL;
          end else if (done) begin
            kind_d = (base_q == next_q) ? K_FINISHED : K_AWAIT;
          end else begin
            kind_d = K_SEND_NEW;
            next_d = next_q + SEQ_BITS'(1);
            if (base_q == next_q) begin
              on_d   = 1'b1;
              tcnt_d = '0;
            end
          end
        end
        OP_ACK: begin
          if (ack_ign) begin
            kind_d = K_ACK_IGN;
          end else begin
            kind_d = K_ACK_OK;
            base_d = ack1[SEQ_BITS-1:0];
            tcnt_d = '0;
            on_d   = (ack1 != EXT_W'(next_q));
          end
        end
        OP_TICK: begin
          if (expire) begin
            tcnt_d = '0;
            on_d   = 1'b1;
            if (rcount != '0) begin
              kind_d = K_RESEND;
              seq_d  = base_q;
              last_d = (rcount == CNT_W'(1));
              idx_d  = CNT_W'(1);
              rcnt_d = rcount;
            end
          end else if (on_q) begin
            tcnt_d = elapsed[15:0];
          end
        end
        default: kind_d = K_NONE;
      endcase
    end else if (cmd_i.step) begin
      kind_d = K_RESEND;
      seq_d  = base_q + SEQ_BITS'(idx_q);
      last_d = stat_o.resend_last;
      idx_d  = idx_q + CNT_W'(1);
    end
  end

  assign load = cmd_i.take || cmd_i.step;

  always_comb begin
    rsp_d.kind          = kind_d;
    rsp_d.seq_number    = seq_d;
    rsp_d.last_of_run   = last_d;
    rsp_d.window_base   = base_d;
    rsp_d.next_sequence = next_d;
    rsp_d.timer_running = on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WINDOW_RST;
      timeout_q   <= TIMEOUT_RST;
      total_q     <= TOTAL_RST;
      base_q      <= SEQ_BITS'(1);
      next_q      <= SEQ_BITS'(1);
      on_q        <= 1'b1;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW:  window_q  <= cfg_wdata_i[4:0];
          REG_TIMEOUT: timeout_q <= cfg_wdata_i;
          REG_TOTAL:   total_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      base_q <= base_d;
      next_q <= next_d;
      on_q   <= on_d;
      tcnt_q <= tcnt_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    rcnt_q <= rcnt_d;
    if (load) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  a_base_le_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= next_q)
    else $error("window base passed next sequence");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EXT_W'(next_q - base_q) <= EXT_W'(WINDOW_MAX))
    else $error("outstanding count exceeds window limit");

  a_step_follows_resend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && out_valid_q |->
      (rsp_q.kind == K_RESEND) && !rsp_q.last_of_run)
    else $error("resend step without open resend run");

endmodule

>>> rtl/go_back_n_sender_window_top.sv
// Go-Back-N sender window control, top level.
// Depends on gbn_pkg, gbn_stream_if, gbn_ctrl and gbn_dp.
//
// Usage:
//   in_if  (sink)   : one transfer per request; op = send / ack / tick,
//                     ack_number used only for acks.
//   out_if (source) : result transfers; every input yields one result,
//                     except a timeout that resends the window, which yields
//                     one result per outstanding sequence, base first.
//                     last_of_run marks the final result of each input.
//   cfg_*           : register writes (window size, timeout, total packets),
//                     done by the user only while the block is idle, which
//                     the block does not enforce.
// Output: a result sits in the output register in the cycle after the input
//   transfer. Throughput: one input per cycle for single-result items while
//   results drain; a resend run of n sequences holds in_if.ready low while
//   it sends one result per unstalled cycle from the shared output register.
// Reset: base and next sequence at 1, timer running with zero elapsed
//   ticks, config registers at 4 / 100 / 1, output register empty.
// Receiver stall: the output register holds its result; the input stays
//   ready only while that register drains in the same cycle.
module go_back_n_sender_window_top import gbn_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  gbn_stream_if.sink           in_if,
  gbn_stream_if.source         out_if
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  req_t  in_data;
  rsp_t  out_data;

  assign in_data     = in_if.data;
  assign in_if.ready = in_ready;
  assign out_if.data = out_data;

  // sequencing: accepts inputs, walks resend runs
  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // window state, timer, config and result register
  gbn_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_data)
  );

endmodule

>>> verif/gbn_window_checker.sv
// Go-Back-N sender window checker: watches both streams and the register port,
// tracks the window state on its own and compares every result transfer.
// Depends on gbn_pkg.
module gbn_window_checker import gbn_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  req_t                 req_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_ready_i,
  input  rsp_t                 rsp_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o,
  output int unsigned          results_o,
  output int unsigned          resends_o,
  output logic [15:0]          base_o,
  output logic [15:0]          next_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [4:0]  win_reg;
  logic [15:0] timeout_reg;
  logic [15:0] total_reg;

  // window state
  logic [15:0] base_q;
  logic [15:0] next_q;
  logic [15:0] tick_cnt_q;
  logic        timer_on_q;

  rsp_t        sender_events[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned resends_seen = 0;
  int unsigned pending_q    = 0;

  assign errors_o  = mismatches;
  assign pending_o = pending_q;
  assign results_o = results_seen;
  assign resends_o = resends_seen;
  assign base_o    = base_q;
  assign next_o    = next_q;

  // result fields carry the state after the step
  task automatic log_event(input kind_e k, input logic [15:0] seq, input logic last);
    rsp_t r;
    r.kind          = k;
    r.seq_number    = seq;
    r.last_of_run   = last;
    r.window_base   = base_q;
    r.next_sequence = next_q;
    r.timer_running = timer_on_q;
    sender_events.push_back(r);
  endtask

  task automatic advance_sender(input req_t r);
    logic [16:0] win_eff;
    logic [16:0] total_eff;
    logic [16:0] ack_inc;
    logic [16:0] elapsed;
    logic [16:0] span;
    logic        fired;
    int unsigned i;
    fired = 1'b0;
    case (r.op)
      OP_SEND: begin
        win_eff   = (win_reg > WINDOW_MAX) ? 17'(WINDOW_MAX) : 17'(win_reg);
        total_eff = (total_reg > SEQ_LAST) ? 17'(SEQ_LAST) : 17'(total_reg);
        if (17'(next_q) >= 17'(base_q) + win_eff) begin
          log_event(K_FULL, next_q, 1'b1);
        end else if (17'(next_q) > total_eff) begin
          log_event((base_q == next_q) ? K_FINISHED : K_AWAIT, next_q, 1'b1);
        end else begin
          if (base_q == next_q) begin
            timer_on_q = 1'b1;
            tick_cnt_q = '0;
          end
          next_q = next_q + 16'd1;
          log_event(K_SEND_NEW, next_q - 16'd1, 1'b1);
        end
      end
      OP_ACK: begin
        ack_inc = 17'(r.ack_number) + 17'd1;
        if (ack_inc < 17'(base_q) || ack_inc > 17'(next_q)) begin
          log_event(K_ACK_IGN, '0, 1'b1);
        end else begin
          base_q     = ack_inc[15:0];
          tick_cnt_q = '0;
          timer_on_q = (base_q != next_q);
          log_event(K_ACK_OK, '0, 1'b1);
        end
      end
      OP_TICK: begin
        if (timer_on_q) begin
          elapsed = 17'(tick_cnt_q) + 17'd1;
          if (elapsed > 17'(timeout_reg)) begin
            span = 17'(next_q - base_q);
            if (span > WINDOW_MAX) span = 17'(WINDOW_MAX);
            tick_cnt_q = '0;
            timer_on_q = 1'b1;
            for (i = 0; i < span; i++) begin
              log_event(K_RESEND, base_q + 16'(i), (i + 1 == span));
            end
            fired = (span != 0);
          end else begin
            tick_cnt_q = elapsed[15:0];
          end
        end
        if (!fired) log_event(K_NONE, '0, 1'b1);
      end
      default: begin
        log_event(K_NONE, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      win_reg     = WINDOW_RST;
      timeout_reg = TIMEOUT_RST;
      total_reg   = TOTAL_RST;
      base_q      = 16'd1;
      next_q      = 16'd1;
      tick_cnt_q  = '0;
      timer_on_q  = 1'b1;
      sender_events.delete();
      pending_q   = 0;
    end else begin
      // a result always leaves after the edge that took its request
      if (rsp_valid_i && rsp_ready_i) begin
        if (sender_events.size() == 0) begin
          $error("unexpected result: kind %0d seq %0d", rsp_i.kind, rsp_i.seq_number);
          mismatches++;
        end else begin
          want = sender_events.pop_front();
          results_seen++;
          if (want.kind == K_RESEND) resends_seen++;
          check_field("kind", 16'(want.kind), 16'(rsp_i.kind));
          check_field("seq_number", want.seq_number, rsp_i.seq_number);
          check_field("last_of_run", 16'(want.last_of_run), 16'(rsp_i.last_of_run));
          check_field("window_base", want.window_base, rsp_i.window_base);
          check_field("next_sequence", want.next_sequence, rsp_i.next_sequence);
          check_field("timer_running", 16'(want.timer_running), 16'(rsp_i.timer_running));
        end
      end
      if (req_valid_i && req_ready_i) advance_sender(req_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW:  win_reg     = cfg_wdata_i[4:0];
          REG_TIMEOUT: timeout_reg = cfg_wdata_i[15:0];
          REG_TOTAL:   total_reg   = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      pending_q = sender_events.size();
    end
  end

endmodule

>>> verif/go_back_n_sender_window_top_tb.sv
// Testbench top for the Go-Back-N sender window: clock, reset, register writes,
// request traffic and receiver back-pressure; the verdict comes from the checker.
// Depends on gbn_pkg, gbn_stream_if, gbn_window_checker and the block's top.
module go_back_n_sender_window_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_pkg::*;

  localparam int unsigned WINDOW_MAX  = 16;
  // worst case is far below this: ~120 requests, up to 16 results each,
  // every result held by a receiver that stalls most cycles
  localparam int unsigned CYCLE_LIMIT = 600_000;
  // opcode the block has no use for; it must answer with kind none
  localparam logic [1:0]  OP_SPARE    = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  // percent of cycles each side holds back
  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned directed_count = 0;

  int unsigned chk_errors;
  int unsigned chk_pending;
  int unsigned chk_results;
  int unsigned chk_resends;
  logic [15:0] cur_base;
  logic [15:0] cur_next;

  gbn_stream_if #(.T(req_t)) req_if ();
  gbn_stream_if #(.T(rsp_t)) rsp_if ();

  go_back_n_sender_window_top #(
    .WINDOW_MAX (WINDOW_MAX)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (req_if),
    .out_if      (rsp_if)
  );

  gbn_window_checker #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_i       (req_if.data),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_i       (rsp_if.data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (chk_errors),
    .pending_o   (chk_pending),
    .results_o   (chk_results),
    .resends_o   (chk_resends),
    .base_o      (cur_base),
    .next_o      (cur_next)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver side: ready is redrawn at every falling edge, so stalls land on
  // every phase of a resend run as well as on single results.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Hard stop in case the block hangs or a result never shows up.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("go_back_n_sender_window_top_tb: done, errors");
    $finish;
  end

  // One request transfer. Entered after a rising edge; drives at the falling
  // edge, optionally idling first, and returns at the edge that took it.
  task automatic push_req(input logic [1:0] op, input logic [15:0] ack);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= '{op: op, ack_number: ack};
    // ready is read before this edge's register updates land
    do @(posedge clk_i); while (!req_if.ready);
    requests_sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken. Each
  // request yields at least one result, so nothing is left in flight after.
  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Register write, only ever issued after settle().
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Ack number biased toward the live range base-1 .. next-1, with duplicates,
  // stale acks and fully random numbers mixed in.
  function automatic logic [15:0] pick_ack();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 16'($urandom_range(cur_next - 16'd1, cur_base - 16'd1));
    if (roll < 70) return cur_base - 16'd1;
    if (roll < 80 && cur_base > 16'd1) return 16'($urandom_range(cur_base - 16'd2, 0));
    return 16'($urandom());
  endfunction

  // Mostly protocol-shaped traffic: send runs of up to sixteen, tick runs of
  // up to tick_run_max, single sends and acks, plus a little noise. The ack
  // field of non-ack requests is random so its bits toggle there too.
  task automatic random_traffic(input int unsigned n_items, input int unsigned tick_run_max);
    int unsigned done_cnt;
    int unsigned pick;
    int unsigned run_len;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        run_len = $urandom_range(16, 1);
        repeat (run_len) push_req(OP_SEND, 16'($urandom()));
        done_cnt += run_len;
      end else if (pick < 27) begin
        run_len = $urandom_range(tick_run_max, 1);
        repeat (run_len) push_req(OP_TICK, 16'($urandom()));
        done_cnt += run_len;
      end else begin
        if (pick < 60)      push_req(OP_SEND, 16'($urandom()));
        else if (pick < 90) push_req(OP_ACK, pick_ack());
        else if (pick < 96) push_req(OP_TICK, 16'($urandom()));
        else                push_req(OP_SPARE, 16'($urandom()));
        done_cnt++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_WINDOW;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;

    // directed part runs under the first idle mix
    src_idle_pct = 12;
    dst_idle_pct = 79;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window 4, timeout 100, one packet
    push_req(OP_TICK, 16'h0000);   // timer runs from reset, count advances
    push_req(OP_ACK, 16'hFFFF);    // far past next-1: ignored
    push_req(OP_SPARE, 16'h0000);  // unused opcode
    settle();

    // timeout 0: every tick with the timer on expires
    cfg_write(REG_TIMEOUT, 16'd0);
    push_req(OP_TICK, 16'h0000);   // expiry with nothing outstanding, timer restarts
    push_req(OP_ACK, 16'h0000);    // base-1 with empty window: taken, timer stops
    push_req(OP_TICK, 16'h0000);   // timer stopped: nothing happens
    push_req(OP_SEND, 16'h0000);   // sequence 1 goes out, timer starts
    push_req(OP_SEND, 16'h0000);   // past the total, ack outstanding: await
    push_req(OP_TICK, 16'h0000);   // resend of sequence 1
    push_req(OP_ACK, 16'h0001);    // all acked
    push_req(OP_SEND, 16'h0000);   // transfer finished
    settle();

    // zero window wins over the end-of-transfer check
    cfg_write(REG_WINDOW, 16'd0);
    cfg_write(REG_TOTAL, 16'd0);
    push_req(OP_SEND, 16'h0000);
    settle();

    // window 2, total beyond the clamp
    cfg_write(REG_WINDOW, 16'd2);
    cfg_write(REG_TOTAL, 16'hFFFF);
    push_req(OP_SEND, 16'h0000);
    push_req(OP_SEND, 16'h0000);
    push_req(OP_SEND, 16'h0000);   // full
    push_req(OP_TICK, 16'h0000);   // two-result resend run
    push_req(OP_ACK, 16'h0000);    // stale
    push_req(OP_ACK, 16'h0001);    // duplicate of base-1, timer restarts
    push_req(OP_ACK, 16'h0003);    // everything acked
    settle();
    directed_count = requests_sent;

    // phase 1: sender mostly busy, receiver mostly stalled
    cfg_write(REG_WINDOW, 16'd5);
    cfg_write(REG_TIMEOUT, 16'd3);
    cfg_write(REG_TOTAL, 16'd40);
    random_traffic(26, 5);
    settle();

    // phase 2: idling swapped; window above the maximum, fast timeout, so
    // full sixteen-sequence resend runs appear
    src_idle_pct = 79;
    dst_idle_pct = 12;
    cfg_write(REG_WINDOW, 16'd31);
    cfg_write(REG_TIMEOUT, 16'd1);
    cfg_write(REG_TOTAL, 16'hFFFF);
    random_traffic(26, 3);
    settle();

    // phase 3: no idling on either side
    src_idle_pct = 0;
    dst_idle_pct = 0;
    cfg_write(REG_WINDOW, 16'd1);
    cfg_write(REG_TIMEOUT, 16'd2);
    cfg_write(REG_TOTAL, 16'd65534);
    random_traffic(16, 4);
    settle();
    cfg_write(REG_WINDOW, 16'd16);
    cfg_write(REG_TIMEOUT, 16'hFFFF);
    random_traffic(16, 4);
    settle();

    repeat (8) @(posedge clk_i);
    $display("run: %0d requests (%0d directed), %0d results checked, %0d resends",
             requests_sent, directed_count, chk_results, chk_resends);
    $display("run: windows 0..31, timeouts 0..65535, totals 0..65535, three idle mixes");
    if (chk_errors == 0) begin
      $display("go_back_n_sender_window_top_tb: done, clean");
    end else begin
      $display("go_back_n_sender_window_top_tb: done, errors");
    end
    $finish;
  end

endmodule
